### rtl/ksc_pkg.sv
// Package for the keyboard scan code translator.
// Holds queue sizing, scan code and command constants, result type and key maps.
// No dependencies.
package ksc_pkg;

    localparam int KSC_QDEPTH = 32;
    localparam int KSC_QAW    = $clog2(KSC_QDEPTH);
    localparam int KSC_QCW    = $clog2(KSC_QDEPTH + 1);
    localparam int KSC_PAW    = 3;
    localparam int KSC_OFD    = 4;
    localparam int KSC_OAW    = $clog2(KSC_OFD);
    localparam int KSC_OCW    = $clog2(KSC_OFD + 1);

    localparam logic [7:0] SC_BKSP     = 8'h0e;
    localparam logic [7:0] SC_ENTER    = 8'h1c;
    localparam logic [7:0] SC_LSHIFT   = 8'h2a;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_LSHIFT_B = 8'haa;
    localparam logic [7:0] SC_RSHIFT_B = 8'hb6;
    localparam logic [7:0] SC_CAPS     = 8'h3a;
    localparam logic [7:0] SC_NUM      = 8'h45;
    localparam logic [7:0] SC_SCROLL   = 8'h46;
    localparam logic [7:0] SC_ACK      = 8'hfa;
    localparam logic [7:0] SC_RESEND   = 8'hfe;

    localparam logic [7:0] KB_SET_LEDS = 8'hed;
    localparam logic [7:0] KB_NONE     = 8'hff;
    localparam logic [7:0] CH_BKSP     = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE     = 8'h20;

    localparam logic FUNC_CODE  = 1'b0;
    localparam logic FUNC_START = 1'b1;
    localparam logic TGT_CON    = 1'b0;
    localparam logic TGT_KBD    = 1'b1;

    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    typedef struct packed {
        logic       target;
        logic [7:0] data;
        logic       last;
    } t_res;

    localparam logic [7:0] PLAIN_MAP [128] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h40, 8'h5b, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFT_MAP [128] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h60, 8'h7b, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
        8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
    };

endpackage

### rtl/ksc_if.sv
// Handshake channel interfaces for the keyboard scan code translator.
// Input channel carries keyboard items, result channel carries translated items.
// No dependencies.
interface ksc_key_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] scan_code;

    modport source (output valid, output func, output scan_code, input ready);
    modport sink (input valid, input func, input scan_code, output ready);
endinterface

interface ksc_res_if;
    logic       valid;
    logic       ready;
    logic       target;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output target, output data, output last, input ready);
    modport sink (input valid, input target, input data, input last, output ready);
endinterface

### rtl/keyboard_scancode_to_char_led.sv
// Keyboard scan code (set 1) translator with LED command queue.
// Depends on ksc_pkg and the channel interfaces in ksc_if.sv.
//
// Usage:
// i_key takes one item per handshake: func 0 carries a received keyboard byte,
// func 1 loads the LEDs from the initial_leds register and queues the LED command.
// o_res delivers up to two result items per input item: a console character or a
// resend first, then at most one command byte for the keyboard; last marks the
// final result of an item. Items that cause no result produce nothing on o_res.
// initial_leds is written through the APB port at address 0 and reads back there.
// After each accept the input drops ready for a second phase (r_p2), because both
// bytes of an LED command go through the single write port of the queue RAM.
// The first result of an item goes through the r_p2 registers and the result buffer to o_res.
// A four-entry result buffer decouples the sides: a stalled receiver stops new
// items only once the buffer cannot take two more results.
// Reset is synchronous: shift, LED, acknowledge state, queue pointers and the
// result buffer are cleared at once, so the block is ready the cycle after reset.
module keyboard_scancode_to_char_led
    import ksc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ksc_key_if.sink              i_key,
    ksc_res_if.source            o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [KSC_PAW-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [2:0]         r_init;
    logic [1:0]         r_shift, n_shift;
    logic [2:0]         r_led, n_led;
    logic               r_await;
    logic [7:0]         r_held;

    logic [7:0]         r_mem [KSC_QDEPTH];
    logic [7:0]         r_rd;
    logic [KSC_QAW-1:0] r_head, r_tail;
    logic [KSC_QCW-1:0] r_qcnt;

    logic               r_p2;
    logic               r_p2_fv;
    logic               r_p2_ft;
    logic [7:0]         r_p2_fd;
    logic               r_p2_enq;
    logic [2:0]         r_p2_led;
    logic               r_p2_empty;

    t_res               r_of [KSC_OFD];
    logic [KSC_OAW-1:0] r_ord, r_owr;
    logic [KSC_OCW-1:0] r_ocnt;

    logic               acc, pop, cfg_we;
    logic               fv, ft, enq, ack;
    logic [7:0]         fd, ch, code;
    logic               q_notfull, mem_we, deq;
    logic [7:0]         mem_wd, deq_byte;
    logic [1:0]         npush;
    t_res               e0, e1;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_init} : 32'd0;

    assign i_key.ready = !r_p2 && (r_ocnt <= KSC_OCW'(KSC_OFD - 2));
    assign acc = i_key.valid && i_key.ready;
    assign code = i_key.scan_code;

    always_comb begin
        n_shift = r_shift;
        n_led   = r_led;
        enq     = 1'b0;
        ack     = 1'b0;
        fv      = 1'b0;
        ft      = TGT_CON;
        fd      = 8'd0;
        ch      = 8'd0;
        if (i_key.func == FUNC_START) begin
            n_led = r_init;
            enq   = 1'b1;
        end else begin
            if (!code[7]) begin
                ch = (r_shift != 2'b00) ? SHIFT_MAP[code[6:0]] : PLAIN_MAP[code[6:0]];
            end
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z
                && ((r_led & LED_CAPS) != 3'b000) == (r_shift != 2'b00)) begin
                ch = ch + CH_CASE;
            end
            if (ch != 8'd0) begin
                fv = 1'b1;
                fd = ch;
            end
            case (code)
                SC_BKSP: begin
                    fv = 1'b1;
                    fd = CH_BKSP;
                end
                SC_ENTER: begin
                    fv = 1'b1;
                    fd = CH_LF;
                end
                SC_LSHIFT:   n_shift = r_shift | 2'b01;
                SC_RSHIFT:   n_shift = r_shift | 2'b10;
                SC_LSHIFT_B: n_shift = r_shift & 2'b10;
                SC_RSHIFT_B: n_shift = r_shift & 2'b01;
                SC_CAPS: begin
                    n_led = r_led ^ LED_CAPS;
                    enq   = 1'b1;
                end
                SC_NUM: begin
                    n_led = r_led ^ LED_NUM;
                    enq   = 1'b1;
                end
                SC_SCROLL: begin
                    n_led = r_led ^ LED_SCROLL;
                    enq   = 1'b1;
                end
                SC_ACK: ack = 1'b1;
                SC_RESEND: begin
                    fv = 1'b1;
                    ft = TGT_KBD;
                    fd = r_held;
                end
                default: ;
            endcase
        end
    end

    // The first queue write happens in the accept cycle, the second in the next one.
    assign q_notfull = r_qcnt < KSC_QCW'(KSC_QDEPTH);
    assign mem_we    = q_notfull && ((acc && enq) || (r_p2 && r_p2_enq));
    assign mem_wd    = r_p2 ? {5'd0, r_p2_led} : KB_SET_LEDS;
    assign deq       = r_p2 && !r_await
                       && ((r_qcnt != '0) || (r_p2_enq && q_notfull));
    // A queue that was empty at accept has its head byte written too late for the read.
    assign deq_byte  = r_p2_empty ? KB_SET_LEDS : r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= mem_wd;
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= 3'd0;
            r_shift <= 2'd0;
            r_led   <= 3'd0;
            r_await <= 1'b0;
            r_held  <= KB_NONE;
            r_head  <= '0;
            r_tail  <= '0;
            r_qcnt  <= '0;
            r_p2    <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_init <= pwdata[2:0];
            end
            if (acc) begin
                r_shift <= n_shift;
                r_led   <= n_led;
                if (ack) begin
                    r_await <= 1'b0;
                    r_held  <= KB_NONE;
                end
            end
            if (deq) begin
                r_await <= 1'b1;
                r_held  <= deq_byte;
                r_head  <= (r_head == KSC_QAW'(KSC_QDEPTH - 1)) ? '0 : r_head + KSC_QAW'(1);
            end
            if (mem_we) begin
                r_tail <= (r_tail == KSC_QAW'(KSC_QDEPTH - 1)) ? '0 : r_tail + KSC_QAW'(1);
            end
            r_qcnt <= r_qcnt + KSC_QCW'(mem_we) - KSC_QCW'(deq);
            r_p2   <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p2_fv    <= fv;
            r_p2_ft    <= ft;
            r_p2_fd    <= fd;
            r_p2_enq   <= enq;
            r_p2_led   <= n_led;
            r_p2_empty <= (r_qcnt == '0);
        end
    end

    always_comb begin
        e0 = '{target: TGT_KBD, data: deq_byte, last: 1'b1};
        e1 = '{target: TGT_KBD, data: deq_byte, last: 1'b1};
        if (r_p2_fv) begin
            e0 = '{target: r_p2_ft, data: r_p2_fd, last: !deq};
        end
        npush = 2'd0;
        if (r_p2) begin
            npush = {1'b0, r_p2_fv} + {1'b0, deq};
        end
    end

    assign pop          = o_res.valid && o_res.ready;
    assign o_res.valid  = r_ocnt != '0;
    assign o_res.target = r_of[r_ord].target;
    assign o_res.data   = r_of[r_ord].data;
    assign o_res.last   = r_of[r_ord].last;

    always_ff @(posedge i_clk) begin
        if (npush != 2'd0) begin
            r_of[r_owr] <= e0;
        end
        if (npush == 2'd2) begin
            r_of[r_owr + KSC_OAW'(1)] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord  <= '0;
            r_owr  <= '0;
            r_ocnt <= '0;
        end else begin
            r_owr  <= r_owr + KSC_OAW'(npush);
            r_ord  <= r_ord + KSC_OAW'(pop);
            r_ocnt <= r_ocnt + KSC_OCW'(npush) - KSC_OCW'(pop);
        end
    end

endmodule

### tb/keyboard_scancode_to_char_led_tb.sv
// Testbench for the keyboard scan code translator: drives random and directed key items,
// predicts console characters and keyboard command bytes, and checks every result item.
// Depends on ksc_pkg, the channel interfaces in ksc_if.sv and keyboard_scancode_to_char_led.
module keyboard_scancode_to_char_led_tb
    import ksc_pkg::*;
;

    typedef struct packed {
        logic       func;
        logic [7:0] code;
    } t_key_item;

    localparam logic [KSC_PAW-1:0] REG_INITIAL_LEDS = '0;
    localparam logic [7:0] KP_FIRST   = 8'h47;
    localparam logic [7:0] KP_LAST    = 8'h53;
    localparam logic [7:0] KEY_BSLASH = 8'h73;
    localparam logic [7:0] KEY_YEN    = 8'h7d;
    localparam logic [7:0] NO_CHAR    = "z";
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 100;
    localparam int RANDOM_PER_PHASE = 270;

    localparam string PLAIN_LO = {"zz1234567890-^zzQWERTYUIOP@[zzAS",
                                  "DFGHJKL;:zz]ZXCVBNM,./z*z zzzzzz"};
    localparam string SHIFT_LO = {"zz!\"#$%&'()~=~zzQWERTYUIOP`{zzAS",
                                  "DFGHJKL+*zz}ZXCVBNM<>?z*z zzzzzz"};
    localparam string KEYPAD   = "789-456+1230.";

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [KSC_PAW-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    ksc_key_if key_ch();
    ksc_res_if res_ch();

    keyboard_scancode_to_char_led dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_key_item pending_keys[$];
    t_res      expected_outputs[$];
    int        n_errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_req = 1'b0;
    logic      hold_done;
    int        hold_left;

    logic [2:0] cfg_initial_leds = 3'd0;
    logic [1:0] shift_held       = 2'b00;
    logic [2:0] led_state        = 3'd0;
    logic       kbd_busy         = 1'b0;
    logic [7:0] kbd_last_sent    = KB_NONE;
    logic [7:0] cmd_fifo [KSC_QDEPTH];
    int         cmd_rd    = 0;
    int         cmd_wr    = 0;
    int         cmd_level = 0;

    function automatic logic [7:0] key_char(input logic [7:0] code, input logic shifted);
        logic [7:0] c;
        c = 8'h00;
        if (code < 8'h40) begin
            c = shifted ? SHIFT_LO[code[5:0]] : PLAIN_LO[code[5:0]];
            if (c == NO_CHAR) begin
                c = 8'h00;
            end
        end else if (code >= KP_FIRST && code <= KP_LAST) begin
            c = KEYPAD[code - KP_FIRST];
        end else if (code == KEY_BSLASH) begin
            c = shifted ? 8'h5f : 8'h5c;
        end else if (code == KEY_YEN) begin
            c = shifted ? 8'h7c : 8'h5c;
        end
        return c;
    endfunction

    function automatic void add_result(input logic tgt, input logic [7:0] d);
        t_res r;
        r.target = tgt;
        r.data   = d;
        r.last   = 1'b0;
        expected_outputs.push_back(r);
    endfunction

    function automatic void push_cmd(input logic [7:0] b);
        if (cmd_level < KSC_QDEPTH) begin
            cmd_fifo[cmd_wr] = b;
            cmd_wr = (cmd_wr + 1) % KSC_QDEPTH;
            cmd_level++;
        end
    endfunction

    function automatic void queue_led_cmd();
        push_cmd(KB_SET_LEDS);
        push_cmd({5'd0, led_state});
    endfunction

    function automatic void translate_key(input logic func, input logic [7:0] code);
        logic [7:0] ch;
        int         n_before;
        t_res       r;
        n_before = expected_outputs.size();
        if (func == FUNC_START) begin
            led_state = cfg_initial_leds;
            queue_led_cmd();
        end else begin
            ch = key_char(code, shift_held != 2'b00);
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z
                    && (((led_state & LED_CAPS) != 0) == (shift_held != 2'b00))) begin
                ch = ch + CH_CASE;
            end
            if (ch != 8'h00) begin
                add_result(TGT_CON, ch);
            end
            case (code)
                SC_BKSP:     add_result(TGT_CON, CH_BKSP);
                SC_ENTER:    add_result(TGT_CON, CH_LF);
                SC_LSHIFT:   shift_held[0] = 1'b1;
                SC_RSHIFT:   shift_held[1] = 1'b1;
                SC_LSHIFT_B: shift_held[0] = 1'b0;
                SC_RSHIFT_B: shift_held[1] = 1'b0;
                SC_CAPS: begin
                    led_state = led_state ^ LED_CAPS;
                    queue_led_cmd();
                end
                SC_NUM: begin
                    led_state = led_state ^ LED_NUM;
                    queue_led_cmd();
                end
                SC_SCROLL: begin
                    led_state = led_state ^ LED_SCROLL;
                    queue_led_cmd();
                end
                SC_ACK: begin
                    kbd_busy = 1'b0;
                    kbd_last_sent = KB_NONE;
                end
                SC_RESEND:   add_result(TGT_KBD, kbd_last_sent);
                default: ;
            endcase
        end
        if (cmd_level != 0 && !kbd_busy) begin
            kbd_last_sent = cmd_fifo[cmd_rd];
            cmd_rd = (cmd_rd + 1) % KSC_QDEPTH;
            cmd_level--;
            kbd_busy = 1'b1;
            add_result(TGT_KBD, kbd_last_sent);
        end
        if (expected_outputs.size() > n_before) begin
            r = expected_outputs.pop_back();
            r.last = 1'b1;
            expected_outputs.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_key_item it;
        if (!i_rst_n) begin
            key_ch.valid     <= 1'b0;
            key_ch.func      <= FUNC_CODE;
            key_ch.scan_code <= 8'h00;
        end else begin
            if (key_ch.valid && key_ch.ready) begin
                translate_key(key_ch.func, key_ch.scan_code);
            end
            if (!key_ch.valid || key_ch.ready) begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_keys.pop_front();
                    key_ch.valid     <= 1'b1;
                    key_ch.func      <= it.func;
                    key_ch.scan_code <= it.code;
                end else begin
                    key_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_outputs.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result: target %0d data %02h last %0d",
                                 $time, res_ch.target, res_ch.data, res_ch.last);
                    end
                end else begin
                    exp_r = expected_outputs.pop_front();
                    if (res_ch.target !== exp_r.target || res_ch.data !== exp_r.data
                            || res_ch.last !== exp_r.last) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display({"%0t: mismatch: expected target %0d data %02h last %0d,",
                                      " got target %0d data %02h last %0d"},
                                     $time, exp_r.target, exp_r.data, exp_r.last,
                                     res_ch.target, res_ch.data, res_ch.last);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left    <= LONG_HOLD;
                hold_done    <= 1'b1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic apb_write(input logic [KSC_PAW-1:0] addr, input logic [2:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {29'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_initial_leds = val;
    endtask

    task automatic apb_check(input logic [KSC_PAW-1:0] addr, input logic [2:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== {29'd0, val}) begin
            n_errors++;
            $display("%0t: register readback: expected %08h, got %08h",
                     $time, {29'd0, val}, prdata);
        end
    endtask

    task automatic drain();
        while (pending_keys.size() != 0 || key_ch.valid || expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void push_key(input logic func, input logic [7:0] code);
        t_key_item it;
        it.func = func;
        it.code = code;
        pending_keys.push_back(it);
    endfunction

    function automatic logic [7:0] pick_lock();
        case ($urandom_range(2))
            0:       return SC_CAPS;
            1:       return SC_NUM;
            default: return SC_SCROLL;
        endcase
    endfunction

    function automatic logic [7:0] pick_shift();
        case ($urandom_range(3))
            0:       return SC_LSHIFT;
            1:       return SC_RSHIFT;
            2:       return SC_LSHIFT_B;
            default: return SC_RSHIFT_B;
        endcase
    endfunction

    task automatic push_directed();
        push_key(FUNC_CODE, 8'h00);
        push_key(FUNC_CODE, 8'hff);
        push_key(FUNC_CODE, 8'h1e);
        push_key(FUNC_CODE, SC_BKSP);
        push_key(FUNC_CODE, SC_ENTER);
        push_key(FUNC_CODE, SC_LSHIFT);
        push_key(FUNC_CODE, 8'h1e);
        push_key(FUNC_CODE, 8'h0b);
        push_key(FUNC_CODE, SC_RSHIFT);
        push_key(FUNC_CODE, SC_LSHIFT_B);
        push_key(FUNC_CODE, KEY_BSLASH);
        push_key(FUNC_CODE, SC_CAPS);
        push_key(FUNC_CODE, 8'h1e);
        push_key(FUNC_CODE, SC_RSHIFT_B);
        push_key(FUNC_CODE, 8'h1e);
        push_key(FUNC_CODE, KEY_YEN);
        push_key(FUNC_CODE, SC_RESEND);
        push_key(FUNC_CODE, SC_ACK);
        push_key(FUNC_CODE, SC_ACK);
        push_key(FUNC_CODE, SC_RESEND);
        push_key(FUNC_CODE, SC_NUM);
        push_key(FUNC_CODE, SC_SCROLL);
        push_key(FUNC_START, 8'hff);
        push_key(FUNC_CODE, KP_LAST);
        repeat (4) push_key(FUNC_CODE, SC_ACK);
    endtask

    task automatic push_random(input int n);
        int k;
        int r;
        int burst;
        k = 0;
        while (k < n) begin
            r = $urandom_range(99);
            if (r < 2) begin
                // A run of lock keys with no acknowledge can overflow the command queue.
                burst = $urandom_range(24, 12);
                repeat (burst) push_key(FUNC_CODE, pick_lock());
                k += burst;
            end else begin
                if (r < 5) begin
                    push_key(FUNC_START, 8'($urandom_range(255)));
                end else if (r < 20) begin
                    push_key(FUNC_CODE, SC_ACK);
                end else if (r < 24) begin
                    push_key(FUNC_CODE, SC_RESEND);
                end else if (r < 33) begin
                    push_key(FUNC_CODE, pick_lock());
                end else if (r < 46) begin
                    push_key(FUNC_CODE, pick_shift());
                end else if (r < 82) begin
                    push_key(FUNC_CODE, 8'($urandom_range(8'h7f)));
                end else begin
                    push_key(FUNC_CODE, 8'($urandom_range(8'hff)));
                end
                k++;
            end
        end
    endtask

    int         send_pcts [6] = '{31, 31, 84, 84, 0, 0};
    int         recv_pcts [6] = '{84, 84, 31, 31, 0, 0};
    logic [2:0] led_vals  [6] = '{3'd5, 3'd0, 3'd7, 3'd2, 3'd3, 3'd6};

    initial begin
        logic [2:0] leds;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            drain();
            leds = (p == 5) ? 3'($urandom_range(7)) : led_vals[p];
            apb_write(REG_INITIAL_LEDS, leds);
            apb_check(REG_INITIAL_LEDS, leds);
            @(posedge i_clk);
            send_idle_pct <= send_pcts[p];
            recv_idle_pct <= recv_pcts[p];
            if (p == 4) begin
                hold_req <= 1'b1;
            end
            @(negedge i_clk);
            push_key(FUNC_START, 8'($urandom_range(255)));
            if (p == 0) begin
                push_directed();
            end
            push_random(RANDOM_PER_PHASE);
        end
        drain();
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
